/* hw/rtl/rfts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radio frame transmit serializer package
// Shared constants, codes and the result descriptor passed between the
// control stage and the output stage.
// ----------------------------------------------------------------------------
package rfts_pkg;

    localparam int FRAME_BYTES_DEF = 48;
    localparam int STORE_BYTES_DEF = 2048;

    // Width of the delay register and of the byte position counter.
    localparam int DELAY_W = 11;
    localparam logic [DELAY_W-1:0] DELAY_RESET = 11'd240;

    localparam logic [7:0] SYNC_BYTE    = 8'h5F;
    localparam int         PREAMBLE_LEN = 3;

    // Input item kinds.
    localparam logic KIND_HOST = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Result status codes.
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_OK   = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;
    localparam logic [1:0] STATUS_FULL = 2'd3;

    // Send phase codes.
    localparam logic [1:0] PH_IDLE     = 2'd0;
    localparam logic [1:0] PH_SYNC     = 2'd1;
    localparam logic [1:0] PH_PREAMBLE = 2'd2;
    localparam logic [1:0] PH_FRAME    = 2'd3;

    // Everything the output stage needs to form one result, apart from the
    // store read data, which is registered in the store and arrives in the following cycle.
    typedef struct packed {
        logic [1:0] status;
        logic       bit_valid;
        logic       use_mem;
        logic [7:0] const_byte;
        logic [2:0] bit_sel;
        logic [5:0] free_frames;
    } res_meta_t;

    // Preamble byte by position; positions beyond the last repeat it.
    function automatic logic [7:0] preamble_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h57;
            2'd1:    b = 8'h75;
            default: b = 8'hFD;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rfts_store.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Frame store
// Single write port, single read port byte memory with registered read data.
// ----------------------------------------------------------------------------
module rfts_store #(
    parameter  int DEPTH  = 2096,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [7:0]        rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* hw/rtl/rfts_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serializer control stage
// Tracks message assembly, ring pointers and the send sequencer, issues store
// accesses and builds the result descriptor for each accepted transaction.
// ----------------------------------------------------------------------------
module rfts_ctrl #(
    parameter  int FRAME_BYTES = 48,
    parameter  int STORE_BYTES = 2048,
    localparam int ADDR_W      = $clog2(STORE_BYTES + FRAME_BYTES)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [rfts_pkg::DELAY_W-1:0] cfg_write_data,
    input  wire logic                         item_accept,
    input  wire logic                         kind,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         message_last,
    input  wire logic                         tx_on,
    output logic                              mem_wr_en,
    output logic      [ADDR_W-1:0]            mem_wr_addr,
    output logic      [7:0]                   mem_wr_data,
    output logic                              mem_rd_en,
    output logic      [ADDR_W-1:0]            mem_rd_addr,
    output rfts_pkg::res_meta_t               meta
);

    import rfts_pkg::*;

    // The physical ring holds one frame more than the accounted store, so a
    // frame whose space has been released can still be read out while the
    // host refills the store.
    localparam int DEPTH        = STORE_BYTES + FRAME_BYTES;
    localparam int STORE_FRAMES = STORE_BYTES / FRAME_BYTES;
    localparam int UF_W         = $clog2(STORE_FRAMES + 1);
    localparam int LEN_W        = $clog2(FRAME_BYTES + 3);
    localparam int CMP_W        = (UF_W > 6) ? UF_W : 6;

    localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W:0]   DEPTH_W     = (ADDR_W + 1)'(DEPTH);
    localparam logic [ADDR_W:0]   FRAME_ADD   = (ADDR_W + 1)'(FRAME_BYTES);
    localparam logic [LEN_W-1:0]  LEN_FRAME   = LEN_W'(FRAME_BYTES);
    localparam logic [LEN_W-1:0]  LEN_FULL    = LEN_W'(FRAME_BYTES + 1);
    localparam logic [LEN_W-1:0]  LEN_SAT     = LEN_W'(FRAME_BYTES + 2);
    localparam logic [UF_W-1:0]   UF_MAX      = UF_W'(STORE_FRAMES);
    localparam logic [CMP_W-1:0]  FREE_SAT    = CMP_W'(63);
    localparam logic [DELAY_W:0]  POS_FRAME   = (DELAY_W + 1)'(FRAME_BYTES);
    localparam logic [DELAY_W:0]  POS_PREAMB  = (DELAY_W + 1)'(PREAMBLE_LEN);

    function automatic logic [ADDR_W-1:0] addr_inc(input logic [ADDR_W-1:0] a);
        return (a == LAST_ADDR) ? '0 : a + ADDR_W'(1);
    endfunction

    function automatic logic [ADDR_W-1:0] addr_add_frame(input logic [ADDR_W-1:0] a);
        logic [ADDR_W:0] sum;
        sum = {1'b0, a} + FRAME_ADD;
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[ADDR_W-1:0];
    endfunction

    logic [DELAY_W-1:0] delay_reg,      delay_next;
    logic [ADDR_W-1:0]  wp_reg,         wp_next;
    logic [ADDR_W-1:0]  rp_reg,         rp_next;
    logic [ADDR_W-1:0]  msg_addr_reg,   msg_addr_next;
    logic [ADDR_W-1:0]  frame_addr_reg, frame_addr_next;
    logic [UF_W-1:0]    used_frames_reg, used_frames_next;
    logic [LEN_W-1:0]   len_reg,        len_next;
    logic               rej_reg,        rej_next;
    logic [1:0]         phase_reg,      phase_next;
    logic [DELAY_W-1:0] byte_pos_reg,   byte_pos_next;
    logic [2:0]         bit_pos_reg,    bit_pos_next;

    logic               store_full;
    logic               rej_eff;
    logic [LEN_W-1:0]   len_inc;
    logic [1:0]         ph_eff;
    logic [DELAY_W-1:0] bp_eff;
    logic [2:0]         bitp_eff;
    logic [ADDR_W-1:0]  faddr_eff;
    logic [DELAY_W:0]   bp_inc;
    logic [CMP_W-1:0]   free_wide;

    assign store_full = (used_frames_reg == UF_MAX);
    assign rej_eff    = (len_reg == '0) ? store_full : rej_reg;
    assign len_inc    = (len_reg < LEN_SAT) ? len_reg + LEN_W'(1) : len_reg;

    always_comb
    begin
        delay_next       = cfg_write_en ? cfg_write_data : delay_reg;
        wp_next          = wp_reg;
        rp_next          = rp_reg;
        msg_addr_next    = msg_addr_reg;
        frame_addr_next  = frame_addr_reg;
        used_frames_next = used_frames_reg;
        len_next         = len_reg;
        rej_next         = rej_reg;
        phase_next       = phase_reg;
        byte_pos_next    = byte_pos_reg;
        bit_pos_next     = bit_pos_reg;

        mem_wr_en   = 1'b0;
        mem_wr_addr = msg_addr_reg;
        mem_wr_data = data_byte;
        mem_rd_en   = 1'b0;
        mem_rd_addr = frame_addr_reg;

        ph_eff    = phase_reg;
        bp_eff    = byte_pos_reg;
        bitp_eff  = bit_pos_reg;
        faddr_eff = frame_addr_reg;
        bp_inc    = '0;

        meta.status     = STATUS_NONE;
        meta.bit_valid  = 1'b0;
        meta.use_mem    = 1'b0;
        meta.const_byte = SYNC_BYTE;
        meta.bit_sel    = bit_pos_reg;

        if (item_accept && kind == KIND_HOST)
        begin
            // The tag byte only latches the write base; the frame bytes
            // follow it at consecutive ring addresses.
            if (len_reg == '0)
            begin
                msg_addr_next = wp_reg;
            end
            else if (len_reg <= LEN_FRAME && !rej_eff)
            begin
                mem_wr_en     = 1'b1;
                msg_addr_next = addr_inc(msg_addr_reg);
            end

            if (message_last)
            begin
                len_next = '0;
                rej_next = 1'b0;
                priority if (len_inc != LEN_FULL)
                begin
                    meta.status = STATUS_BAD;
                end
                else if (rej_eff)
                begin
                    meta.status = STATUS_FULL;
                end
                else
                begin
                    meta.status      = STATUS_OK;
                    wp_next          = msg_addr_next;
                    used_frames_next = used_frames_reg + UF_W'(1);
                end
            end
            else
            begin
                len_next = len_inc;
                rej_next = rej_eff;
            end
        end
        else if (item_accept && !(phase_reg == PH_IDLE && used_frames_reg == '0))
        begin
            if (phase_reg == PH_IDLE)
            begin
                bp_eff   = '0;
                bitp_eff = '0;
                if (!tx_on)
                begin
                    ph_eff = (delay_reg == '0) ? PH_PREAMBLE : PH_SYNC;
                end
                else
                begin
                    ph_eff           = PH_FRAME;
                    faddr_eff        = rp_reg;
                    rp_next          = addr_add_frame(rp_reg);
                    used_frames_next = used_frames_reg - UF_W'(1);
                end
            end

            meta.bit_valid = 1'b1;
            meta.bit_sel   = bitp_eff;

            unique case (ph_eff)
                PH_PREAMBLE:
                begin
                    meta.const_byte = preamble_byte(bp_eff[1:0]);
                end
                PH_FRAME:
                begin
                    meta.use_mem = 1'b1;
                    mem_rd_en    = 1'b1;
                    mem_rd_addr  = faddr_eff;
                end
                default:
                begin
                    meta.const_byte = SYNC_BYTE;
                end
            endcase

            bp_inc          = {1'b0, bp_eff} + (DELAY_W + 1)'(1);
            bit_pos_next    = bitp_eff + 3'd1;
            phase_next      = ph_eff;
            byte_pos_next   = bp_eff;
            frame_addr_next = faddr_eff;

            if (bitp_eff == 3'd7)
            begin
                byte_pos_next = bp_inc[DELAY_W-1:0];
                unique case (ph_eff)
                    PH_SYNC:
                    begin
                        if (bp_inc >= {1'b0, delay_reg})
                        begin
                            phase_next    = PH_PREAMBLE;
                            byte_pos_next = '0;
                        end
                    end
                    PH_PREAMBLE:
                    begin
                        if (bp_inc >= POS_PREAMB)
                        begin
                            phase_next    = PH_IDLE;
                            byte_pos_next = '0;
                        end
                    end
                    PH_FRAME:
                    begin
                        frame_addr_next = addr_inc(faddr_eff);
                        if (bp_inc >= POS_FRAME)
                        begin
                            phase_next    = PH_IDLE;
                            byte_pos_next = '0;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        // The store only ever moves by whole frames, so free frames is the
        // frame capacity less the frames held.
        free_wide        = CMP_W'(UF_MAX - used_frames_next);
        meta.free_frames = (free_wide > FREE_SAT) ? 6'd63 : free_wide[5:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg       <= DELAY_RESET;
            wp_reg          <= '0;
            rp_reg          <= '0;
            msg_addr_reg    <= '0;
            frame_addr_reg  <= '0;
            used_frames_reg <= '0;
            len_reg         <= '0;
            rej_reg         <= 1'b0;
            phase_reg       <= PH_IDLE;
            byte_pos_reg    <= '0;
            bit_pos_reg     <= '0;
        end
        else
        begin
            delay_reg       <= delay_next;
            wp_reg          <= wp_next;
            rp_reg          <= rp_next;
            msg_addr_reg    <= msg_addr_next;
            frame_addr_reg  <= frame_addr_next;
            used_frames_reg <= used_frames_next;
            len_reg         <= len_next;
            rej_reg         <= rej_next;
            phase_reg       <= phase_next;
            byte_pos_reg    <= byte_pos_next;
            bit_pos_reg     <= bit_pos_next;
        end
    end

    a_store_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_frames_reg <= UF_MAX)
        else $error("Stored frame count exceeds the store capacity.");

    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
        else $error("Host write hits the frame being sent.");

    a_idle_positions: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (bit_pos_reg == '0 && byte_pos_reg == '0))
        else $error("Send positions not cleared while idle.");

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_SAT)
        else $error("Message length counter beyond saturation.");

endmodule
`default_nettype wire

/* hw/rtl/rfts_out.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Serializer output stage
// Holds each descriptor while the store read completes, picks the output
// bit and keeps the result in an output register for the receiver.
// ----------------------------------------------------------------------------
module rfts_out (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                item_accept,
    input  rfts_pkg::res_meta_t      meta_in,
    input  wire logic [7:0]          mem_rd_data,
    output logic                     item_stall,
    output logic                     result_valid,
    input  wire logic                result_stall,
    output logic      [1:0]          status,
    output logic                     bit_valid,
    output logic                     bit_value,
    output logic      [5:0]          free_frames
);

    import rfts_pkg::*;

    logic       p1_valid_reg, p1_valid_next;
    res_meta_t  p1_meta_reg;
    logic       out_valid_reg, out_valid_next;
    logic [1:0] status_reg;
    logic       bit_valid_reg;
    logic       bit_value_reg;
    logic [5:0] free_frames_reg;
    logic       p1_move;
    logic [7:0] sel_byte;
    logic       sel_bit;

    assign p1_move    = p1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = p1_valid_reg && !p1_move;

    assign sel_byte = p1_meta_reg.use_mem ? mem_rd_data : p1_meta_reg.const_byte;
    assign sel_bit  = p1_meta_reg.bit_valid && sel_byte[3'd7 - p1_meta_reg.bit_sel];

    always_comb
    begin
        p1_valid_next = item_accept || (p1_valid_reg && !p1_move);
        out_valid_next = p1_move || (out_valid_reg && result_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept)
        begin
            p1_meta_reg <= meta_in;
        end
        if (p1_move)
        begin
            status_reg      <= p1_meta_reg.status;
            bit_valid_reg   <= p1_meta_reg.bit_valid;
            bit_value_reg   <= sel_bit;
            free_frames_reg <= p1_meta_reg.free_frames;
        end
    end

    assign result_valid = out_valid_reg;
    assign status       = status_reg;
    assign bit_valid    = bit_valid_reg;
    assign bit_value    = bit_value_reg;
    assign free_frames  = free_frames_reg;

    a_stall_needs_held: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (p1_valid_reg && out_valid_reg))
        else $error("Input stalled with a free pipeline slot.");

endmodule
`default_nettype wire

/* hw/rtl/radio_frame_tx_serializer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Radio frame transmit serializer
// Collects host messages into a ring store and serialises frames, sync and
// preamble bytes onto the modem bit clock, one bit per tick transaction.
// ----------------------------------------------------------------------------
// Usage:
// The item channel (item_valid / item_stall) carries one transaction per host
// byte (kind 0) or per modem bit slot (kind 1). The result channel
// (result_valid / result_stall) returns exactly one result per item: a status
// on the last byte of a message, an output bit on a tick unless idle with no
// frame stored, and always the number of whole frames the store can still take.
// An accepted item reaches the result ports through two register stages, the
// middle stage and the output register. One item is taken every cycle while
// item_stall is low; each item makes at most one store access (a byte write
// for a frame byte of a message, a byte read for each bit of a stored frame)
// on the single write and single read port of the frame store.
// A stalled receiver holds the output register; one more item may still be
// taken into the middle stage before item_stall rises.
// Reset clears all pointers, counters and the sequencer and loads the sync
// byte count with 240; the store needs no clearing, as only committed bytes
// are read. The delay register is written through cfg_write_en / cfg_write_data.
// ----------------------------------------------------------------------------
module radio_frame_tx_serializer #(
    parameter int FRAME_BYTES = rfts_pkg::FRAME_BYTES_DEF,
    parameter int STORE_BYTES = rfts_pkg::STORE_BYTES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_en,
    input  wire logic [rfts_pkg::DELAY_W-1:0] cfg_write_data,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire logic                         kind,
    input  wire logic [7:0]                   data_byte,
    input  wire logic                         message_last,
    input  wire logic                         tx_on,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output logic      [1:0]                   status,
    output logic                              bit_valid,
    output logic                              bit_value,
    output logic      [5:0]                   free_frames
);

    import rfts_pkg::*;

    // One spare frame of physical store lets a released frame drain while
    // the host fills the space it gave back.
    localparam int STORE_DEPTH = STORE_BYTES + FRAME_BYTES;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    logic              item_accept;
    logic              mem_wr_en;
    logic [ADDR_W-1:0] mem_wr_addr;
    logic [7:0]        mem_wr_data;
    logic              mem_rd_en;
    logic [ADDR_W-1:0] mem_rd_addr;
    logic [7:0]        mem_rd_data;
    res_meta_t         meta;

    // An item transaction completes when valid meets no stall.
    assign item_accept = item_valid && !item_stall;

    // Control stage: message assembly, ring pointers and the send sequencer.
    rfts_ctrl #(
        .FRAME_BYTES (FRAME_BYTES),
        .STORE_BYTES (STORE_BYTES)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .item_accept    (item_accept),
        .kind           (kind),
        .data_byte      (data_byte),
        .message_last   (message_last),
        .tx_on          (tx_on),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .meta           (meta)
    );

    // Frame store: the read data is registered and lands alongside the descriptor
    // in the output stage in the cycle after the access.
    rfts_store #(
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    // Output stage: bit selection and the result register.
    rfts_out u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_accept  (item_accept),
        .meta_in      (meta),
        .mem_rd_data  (mem_rd_data),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .bit_valid    (bit_valid),
        .bit_value    (bit_value),
        .free_frames  (free_frames)
    );

endmodule
`default_nettype wire
